// ----- hw/rtl/tmcw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_pkg
// Types, codes and helpers shared by the text console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int unsigned COL_W      = 7;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned IDX_W      = ROW_W + COL_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

  localparam logic [COLOR_W-1:0] FG_RESET   = 4'd15;
  localparam logic [COLOR_W-1:0] BG_RESET   = 4'd0;
  localparam logic [COL_W-1:0]   COLS_RESET = 7'd80;
  localparam logic [ROW_W-1:0]   ROWS_RESET = 5'd25;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOREGROUND = 3'd0,
    CFG_BACKGROUND = 3'd1,
    CFG_COLUMNS    = 3'd2,
    CFG_ROWS       = 3'd3
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] rows;
  } geom_t;

  typedef struct packed {
    logic put;
    logic home;
  } cur_cmd_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [COLOR_W-1:0] fg,
                                                  input logic [COLOR_W-1:0] bg,
                                                  input logic [CHAR_W-1:0]  ch);
    return {bg, fg, ch};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tmcw_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tmcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hw/rtl/tmcw_cursor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_cursor
// Cursor registers, advance/wrap rules and cell address for a put.
// ----------------------------------------------------------------------------
module tmcw_cursor
  import tmcw_pkg::*;
#(
  parameter int unsigned ADDR_W = 11
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cur_cmd_t          cmd_i,
  input  wire logic [CHAR_W-1:0] char_i,
  input  wire geom_t             geom_i,
  output logic      [ROW_W-1:0]  row_o,
  output logic      [COL_W-1:0]  col_o,
  output logic                   wr_en_o,
  output logic      [ADDR_W-1:0] wr_addr_o
);

  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic [ROW_W-1:0] row_wrap;
  logic [IDX_W-1:0] row_base;
  logic [IDX_W-1:0] idx;
  logic             in_area;

  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign row_wrap = (row_inc >= {1'b0, geom_i.rows}) ? '0 : row_inc[ROW_W-1:0];
  assign in_area  = (row_q < geom_i.rows) && (col_q < geom_i.cols);
  assign row_base = IDX_W'(row_q) * IDX_W'(geom_i.cols);
  assign idx      = row_base + IDX_W'(col_q);

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    wr_en_o = 1'b0;
    if (cmd_i.home) begin
      row_d = '0;
      col_d = '0;
    end else if (cmd_i.put) begin
      if (char_i == NEWLINE_CODE) begin
        row_d = row_wrap;
        col_d = '0;
      end else begin
        wr_en_o = in_area;
        if (col_inc >= {1'b0, geom_i.cols}) begin
          col_d = '0;
          row_d = row_wrap;
        end else begin
          col_d = col_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign row_o     = row_q;
  assign col_o     = col_q;
  assign wr_addr_o = ADDR_W'(idx);

endmodule
`default_nettype wire

// ----- hw/rtl/tmcw_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_ctrl
// Command sequencer: accepts items, sweeps the store on clear, issues cell
// reads and raises the result strobe.
// ----------------------------------------------------------------------------
module tmcw_ctrl
  import tmcw_pkg::*;
#(
  parameter int unsigned ADDR_W = 11
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire mode_e             mode_i,
  input  wire logic [ROW_W-1:0]  read_row_i,
  input  wire logic [COL_W-1:0]  read_col_i,
  input  wire geom_t             geom_i,
  input  wire logic [CELL_W-1:0] blank_i,
  input  wire logic              put_we_i,
  input  wire logic [ADDR_W-1:0] put_addr_i,
  input  wire logic [CELL_W-1:0] put_data_i,
  input  wire logic [CELL_W-1:0] ram_rdata_i,
  output cur_cmd_t               cmd_o,
  output logic                   ram_we_o,
  output logic      [ADDR_W-1:0] ram_waddr_o,
  output logic      [CELL_W-1:0] ram_wdata_o,
  output logic                   ram_re_o,
  output logic      [ADDR_W-1:0] ram_raddr_o,
  output logic                   busy_o,
  output logic                   done_o,
  output logic      [CELL_W-1:0] cell_word_o
);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] last_q, last_d;
  logic [CELL_W-1:0] blank_q, blank_d;
  logic              done_q, done_d;
  logic              rd_hit_q;
  logic              accept;
  logic              rd_hit;
  logic [IDX_W-1:0]  rd_base;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  area;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign rd_hit  = (read_row_i < geom_i.rows) && (read_col_i < geom_i.cols);
  assign rd_base = IDX_W'(read_row_i) * IDX_W'(geom_i.cols);
  assign rd_idx  = rd_base + IDX_W'(read_col_i);
  assign area    = IDX_W'(geom_i.rows) * IDX_W'(geom_i.cols);

  assign cmd_o.put   = accept && (mode_i == MODE_PUT);
  assign cmd_o.home  = accept && (mode_i == MODE_CLEAR);
  assign ram_re_o    = accept && (mode_i == MODE_READ) && rd_hit;
  assign ram_raddr_o = ADDR_W'(rd_idx);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    blank_d     = blank_q;
    done_d      = 1'b0;
    ram_we_o    = put_we_i;
    ram_waddr_o = put_addr_i;
    ram_wdata_o = put_data_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_CLEAR) begin
            state_d = ST_CLEAR;
            cnt_d   = '0;
            last_d  = ADDR_W'(area - 1'b1);
            blank_d = blank_i;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q;
        ram_wdata_o = blank_q;
        if (cnt_q == last_q) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      rd_hit_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      rd_hit_q <= ram_re_o;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    blank_q <= blank_d;
  end

  assign busy_o      = (state_q == ST_CLEAR);
  assign done_o      = done_q;
  assign cell_word_o = rd_hit_q ? ram_rdata_i : '0;

  a_sweep_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (cnt_q <= last_q))
    else $error("clear sweep counter past last cell");

  a_clear_enters_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == MODE_CLEAR)) |=> (state_q == ST_CLEAR))
    else $error("clear transaction did not start sweep");

  a_read_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_hit_q |-> done_q)
    else $error("read data without result strobe");

  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(accept && (mode_i != MODE_CLEAR)) ||
                $past((state_q == ST_CLEAR) && (cnt_q == last_q))))
    else $error("result strobe without a finished transaction");

  a_put_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    put_we_i |-> (state_q == ST_IDLE))
    else $error("put write during clear sweep");

endmodule
`default_nettype wire

// ----- hw/rtl/text_mode_console_writer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_console_writer
// Character-cell text console: cursor, cell store, put/clear/read commands.
//
//   channel  direction  handshake                    payload
//   command  in         start_i, busy_o              mode_i, character_i,
//                                                    read_row_i, read_column_i
//   result   out        done_o (one-cycle strobe)    cell_word_o, cursor_row_o,
//                                                    cursor_column_o
//   config   in         cfg_valid_i, cfg_ready_o     cfg_index_i, cfg_data_i
//
// Put, read and no-op strobe their result in the cycle after start_i, and a
// new command is taken every cycle while busy_o is low.
// Clear holds busy_o while it sweeps the store, one cell per cycle through
// the single RAM write port, and strobes its result in the cycle after the
// last sweep write, when busy_o has already dropped.
// Reset returns cursor and configuration to their defaults only; the cell
// store holds no defined value until written or cleared. done_o cannot be
// held off.
// ----------------------------------------------------------------------------
module text_mode_console_writer
  import tmcw_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 80,
  parameter int unsigned MAX_ROWS    = 25
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [MODE_W-1:0]     mode_i,
  input  wire logic [CHAR_W-1:0]     character_i,
  input  wire logic [ROW_W-1:0]      read_row_i,
  input  wire logic [COL_W-1:0]      read_column_i,
  output logic                       done_o,
  output logic      [CELL_W-1:0]     cell_word_o,
  output logic      [ROW_W-1:0]      cursor_row_o,
  output logic      [COL_W-1:0]      cursor_column_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [COLOR_W-1:0] fg_q, bg_q;
  logic [COL_W-1:0]   cols_q;
  logic [ROW_W-1:0]   rows_q;
  geom_t              geom;
  cur_cmd_t           cmd;
  logic               put_we;
  logic [ADDR_W-1:0]  put_addr;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q   <= FG_RESET;
      bg_q   <= BG_RESET;
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FOREGROUND: fg_q   <= cfg_data_i[COLOR_W-1:0];
        CFG_BACKGROUND: bg_q   <= cfg_data_i[COLOR_W-1:0];
        CFG_COLUMNS:    cols_q <= cfg_data_i[COL_W-1:0];
        CFG_ROWS:       rows_q <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  assign geom.cols = (cols_q == '0) ? COL_W'(1) :
                     ((int'(cols_q) > int'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS) : cols_q);
  assign geom.rows = (rows_q == '0) ? ROW_W'(1) :
                     ((int'(rows_q) > int'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : rows_q);

  tmcw_cursor #(
    .ADDR_W(ADDR_W)
  ) u_cursor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .char_i   (character_i),
    .geom_i   (geom),
    .row_o    (cursor_row_o),
    .col_o    (cursor_column_o),
    .wr_en_o  (put_we),
    .wr_addr_o(put_addr)
  );

  tmcw_ctrl #(
    .ADDR_W(ADDR_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .mode_i     (mode_e'(mode_i)),
    .read_row_i (read_row_i),
    .read_col_i (read_column_i),
    .geom_i     (geom),
    .blank_i    (make_cell(fg_q, bg_q, SPACE_CODE)),
    .put_we_i   (put_we),
    .put_addr_i (put_addr),
    .put_data_i (make_cell(fg_q, bg_q, character_i)),
    .ram_rdata_i(ram_rdata),
    .cmd_o      (cmd),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .cell_word_o(cell_word_o)
  );

  tmcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule
`default_nettype wire
